// ===== rtl/core/wal_pkg.sv =====
// wal_pkg: request, status and mode codes and the controller state type
// for the wear-aware block list. No dependencies.
package wal_pkg;

	localparam logic [2:0] REQ_APPEND = 3'd0;
	localparam logic [2:0] REQ_POP    = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_MEMBER = 3'd3;
	localparam logic [2:0] REQ_SELECT = 3'd4;
	localparam logic [2:0] REQ_SETWR  = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [1:0] MODE_YOUNG  = 2'd0;
	localparam logic [1:0] MODE_OLD    = 2'd1;
	localparam logic [1:0] MODE_THRESH = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} wal_state_t;

endpackage

// ===== rtl/core/wal_ram.sv =====
// wal_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/wear_aware_block_list.sv =====
// Channel  | dir | payload
// s_axis   | in  | tdata: block_index, wear_threshold, wear_value; tuser: req_type, select_mode
// m_axis   | out | tdata: result_index, entry_count; tuser: status, is_present
//
// Append, set wear and unknown codes are answered from the idle state, their
// result registered on acceptance. Pop, remove, membership and select walk the
// list RAM one entry per cycle through the single list read port; select also
// reads each entry's wear through the list -> wear read chain.
// After reset the wear RAM is cleared, one entry per cycle, with no request
// taken. A stalled result holds; a new request waits for it.
// Depends on wal_pkg and wal_ram.
module wear_aware_block_list #(
	parameter int LIST_DEPTH  = 256,
	parameter int BLOCK_COUNT = 256,
	parameter int WEAR_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // block_index, wear_threshold, wear_value
	input  logic [4:0]  s_axis_tuser,  // req_type, select_mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // result_index, entry_count, zero pad
	output logic [2:0]  m_axis_tuser   // status, is_present
);
	import wal_pkg::*;

	localparam int AW  = $clog2(LIST_DEPTH);
	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int BAW = $clog2(BLOCK_COUNT);

	wal_state_t state_q, state_d;

	logic [2:0]  in_req;
	logic [7:0]  in_blk;
	logic [1:0]  in_mode;
	logic [15:0] in_thr, in_val;
	logic        accept, out_free, in_walk, in_blk_ok;
	logic [31:0] in_blk32, in_val32;

	logic [2:0]  req_q;
	logic [7:0]  blk_q;
	logic [1:0]  mode_q;
	logic [15:0] thr_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] rd_idx_q;
	logic [BAW-1:0] clr_q;

	logic        v_s1, v_s2, first_s2, ok_s2;
	logic [AW-1:0] pos_s1;
	logic [7:0]  ent_s2;
	logic        found_q;
	logic [7:0]  res_q, cand_q;
	logic [WEAR_BITS-1:0] cw_q;

	logic        issue, shift_on, match_s1, rd_ok, take;
	logic        lst_we, wr_we, load_imm, load_done, len_dec;
	logic [AW-1:0] lst_waddr;
	logic [7:0]  lst_wdata, lst_rdata;
	logic [BAW-1:0] wr_waddr, wr_raddr;
	logic [WEAR_BITS-1:0] wr_wdata, wr_rdata, we_s2;
	logic [31:0] rd32, we32, cw32;

	logic        m_valid_q;
	logic [1:0]  m_status_q;
	logic [7:0]  m_res_q;
	logic        m_pres_q;
	logic [8:0]  m_cnt_q;
	logic [1:0]  o_status;
	logic [7:0]  o_res;
	logic        o_pres;
	logic [CW-1:0] o_len;
	logic [31:0] o_len32;

	assign in_req   = s_axis_tuser[2:0];
	assign in_mode  = s_axis_tuser[4:3];
	assign in_blk   = s_axis_tdata[7:0];
	assign in_thr   = s_axis_tdata[23:8];
	assign in_val   = s_axis_tdata[39:24];
	assign in_blk32 = 32'(in_blk);
	assign in_val32 = 32'(in_val);
	assign in_blk_ok = in_blk32 < 32'(BLOCK_COUNT);
	assign in_walk  = (in_req inside {REQ_POP, REQ_REMOVE, REQ_MEMBER, REQ_SELECT});

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	wal_ram #(.WIDTH(8), .DEPTH(LIST_DEPTH)) u_list (
		.clk   (clk),
		.we    (lst_we),
		.waddr (lst_waddr),
		.wdata (lst_wdata),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (lst_rdata)
	);

	wal_ram #(.WIDTH(WEAR_BITS), .DEPTH(BLOCK_COUNT)) u_wear (
		.clk   (clk),
		.we    (wr_we),
		.waddr (wr_waddr),
		.wdata (wr_wdata),
		.raddr (wr_raddr),
		.rdata (wr_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == BAW'(BLOCK_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept && in_walk) state_d = ST_WALK;
			ST_WALK:  if (!issue && !v_s1 && !v_s2) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign rd32     = 32'(lst_rdata);
	assign rd_ok    = rd32 < 32'(BLOCK_COUNT);
	assign wr_raddr = rd32[BAW-1:0];
	assign match_s1 = (req_q == REQ_POP) ? (pos_s1 == '0) : (lst_rdata == blk_q);
	assign shift_on = v_s1 && found_q && (req_q == REQ_POP || req_q == REQ_REMOVE);

	assign we_s2 = ok_s2 ? wr_rdata : '0;
	assign we32  = 32'(we_s2);
	assign cw32  = 32'(cw_q);

	always_comb begin
		case (mode_q)
			MODE_YOUNG:  take = we32 <= cw32;
			MODE_OLD:    take = we32 >= cw32;
			MODE_THRESH: take = (we32 <= cw32) && (we32 >= 32'(thr_q));
			default:     take = 1'b0;
		endcase
	end

	// control strobes and result fields
	always_comb begin
		issue     = 1'b0;
		lst_we    = 1'b0;
		lst_waddr = len_q[AW-1:0];
		lst_wdata = in_blk;
		wr_we     = 1'b0;
		wr_waddr  = clr_q;
		wr_wdata  = '0;
		load_imm  = 1'b0;
		load_done = 1'b0;
		len_dec   = 1'b0;
		o_status  = STAT_OK;
		o_res     = '0;
		o_pres    = 1'b0;
		o_len     = len_q;
		unique case (state_q)
			ST_CLEAR: wr_we = 1'b1;
			ST_IDLE: begin
				if (accept && !in_walk) begin
					load_imm = 1'b1;
					if (in_req == REQ_APPEND) begin
						if (len_q >= CW'(LIST_DEPTH)) begin
							o_status = STAT_FULL;
						end else begin
							lst_we = 1'b1;
							o_len  = len_q + 1'b1;
						end
					end
					if (in_req == REQ_SETWR && in_blk_ok) begin
						wr_we    = 1'b1;
						wr_waddr = in_blk32[BAW-1:0];
						wr_wdata = in_val32[WEAR_BITS-1:0];
					end
				end
			end
			ST_WALK: begin
				issue = rd_idx_q < len_q;
				if (shift_on) begin
					lst_we    = 1'b1;
					lst_waddr = pos_s1 - 1'b1;
					lst_wdata = lst_rdata;
				end
				len_dec = !issue && !v_s1 && !v_s2 && found_q &&
					(req_q == REQ_POP || req_q == REQ_REMOVE);
			end
			ST_DONE: begin
				load_done = out_free;
				case (req_q)
					REQ_POP, REQ_REMOVE: begin
						o_status = found_q ? STAT_OK : STAT_EMPTY;
						o_res    = found_q ? res_q : '0;
					end
					REQ_MEMBER: o_pres = found_q;
					default: begin
						o_status = (len_q == '0) ? STAT_EMPTY : STAT_OK;
						o_res    = (len_q == '0) ? '0 : cand_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign o_len32 = 32'(o_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			len_q     <= '0;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (lst_we && state_q == ST_IDLE) len_q <= len_q + 1'b1;
			if (len_dec) len_q <= len_q - 1'b1;
			if (accept) rd_idx_q <= '0;
			else if (issue) rd_idx_q <= rd_idx_q + 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1 && req_q == REQ_SELECT;
			if (accept) found_q <= 1'b0;
			else if (v_s1 && match_s1 && req_q != REQ_SELECT) found_q <= 1'b1;
			if (load_imm || load_done) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_req;
			blk_q  <= in_blk;
			mode_q <= in_mode;
			thr_q  <= in_thr;
		end
		pos_s1   <= rd_idx_q[AW-1:0];
		ent_s2   <= lst_rdata;
		ok_s2    <= rd_ok;
		first_s2 <= pos_s1 == '0;
		if (v_s1 && match_s1 && !found_q) res_q <= lst_rdata;
		if (v_s2 && (first_s2 || take)) begin
			cand_q <= ent_s2;
			cw_q   <= we_s2;
		end
		if (load_imm || load_done) begin
			m_status_q <= o_status;
			m_res_q    <= o_res;
			m_pres_q   <= o_pres;
			m_cnt_q    <= o_len32[8:0];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_cnt_q, m_res_q};
	assign m_axis_tuser  = {m_pres_q, m_status_q};

endmodule

// ===== tb/sv/wear_aware_block_list_checker.sv =====
`timescale 1ns / 100ps
// Checker for wear_aware_block_list: watches both stream channels, predicts
// each result from its own list and wear table, and counts mismatches. Uses wal_pkg.
module wear_aware_block_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [4:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending,
	output int          result_total
);
	import wal_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] index;
		logic       present;
		logic [8:0] count;
	} answer_t;

	logic [7:0]  blocks[$];
	logic [15:0] wear[256];
	answer_t     answers[$];

	function automatic int find_block(input logic [7:0] blk);
		foreach (blocks[i])
			if (blocks[i] == blk) return i;
		return -1;
	endfunction

	function automatic answer_t serve(input logic [2:0] req, input logic [7:0] blk,
			input logic [1:0] mode, input logic [15:0] thr, input logic [15:0] val);
		answer_t a;
		int pos;
		logic [7:0] cand;
		logic take;
		a = '0;
		case (req)
			REQ_APPEND: begin
				if (blocks.size() >= 256) a.status = STAT_FULL;
				else blocks.push_back(blk);
			end
			REQ_POP: begin
				if (blocks.size() == 0) a.status = STAT_EMPTY;
				else a.index = blocks.pop_front();
			end
			REQ_REMOVE: begin
				pos = find_block(blk);
				if (pos < 0) a.status = STAT_EMPTY;
				else begin
					a.index = blocks[pos];
					blocks.delete(pos);
				end
			end
			REQ_MEMBER: a.present = find_block(blk) >= 0;
			REQ_SELECT: begin
				if (blocks.size() == 0) a.status = STAT_EMPTY;
				else begin
					cand = blocks[0];
					for (int i = 1; i < blocks.size(); i++) begin
						case (mode)
							MODE_YOUNG:  take = wear[blocks[i]] <= wear[cand];
							MODE_OLD:    take = wear[blocks[i]] >= wear[cand];
							MODE_THRESH: take = wear[blocks[i]] <= wear[cand]
								&& wear[blocks[i]] >= thr;
							default:     take = 1'b0;
						endcase
						if (take) cand = blocks[i];
					end
					a.index = cand;
				end
			end
			REQ_SETWR: wear[blk] = val;
			default: ;
		endcase
		a.count = 9'(blocks.size());
		return a;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch #%0d %s: got %0h expected %0h", result_total, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_total = 0;
		pending = 0;
		foreach (wear[i]) wear[i] = '0;
	end

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			answers.push_back(serve(s_axis_tuser[2:0], s_axis_tdata[7:0],
				s_axis_tuser[4:3], s_axis_tdata[23:8], s_axis_tdata[39:24]));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_total++;
			if (answers.size() == 0) begin
				report("unexpected result", 32'd1, 32'd0);
			end else begin
				a = answers.pop_front();
				if (m_axis_tuser[1:0] != a.status)
					report("status", 32'(m_axis_tuser[1:0]), 32'(a.status));
				if (m_axis_tdata[7:0] != a.index)
					report("index", 32'(m_axis_tdata[7:0]), 32'(a.index));
				if (m_axis_tuser[2] != a.present)
					report("present", 32'(m_axis_tuser[2]), 32'(a.present));
				if (m_axis_tdata[16:8] != a.count)
					report("count", 32'(m_axis_tdata[16:8]), 32'(a.count));
			end
		end
		pending = answers.size();
	end

endmodule

// ===== tb/sv/wear_aware_block_list_test.sv =====
`timescale 1ns / 100ps
// Top of the wear_aware_block_list testbench: clock, reset, request stimulus
// with random idling, and the verdict. Needs wal_pkg and the checker module.
module wear_aware_block_list_test;
	import wal_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [4:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	int          fail_count, pending, result_total;
	int          idle_cycles = 0;
	int          model_len = 0;
	bit          calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	wear_aware_block_list u_dut (.*);

	wear_aware_block_list_checker u_check (.*);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	end

	task automatic send(input logic [2:0] req, input logic [7:0] blk,
			input logic [1:0] mode = MODE_YOUNG, input logic [15:0] thr = 16'd1,
			input logic [15:0] val = 16'd0);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {mode, req};
		s_axis_tdata  <= {val, thr, blk};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (req == REQ_APPEND && model_len < 256) model_len++;
		if ((req == REQ_POP || req == REQ_SELECT) && model_len > 0 && req == REQ_POP)
			model_len--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [2:0] r;
		int k, mix;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty-list cases, extremes, unknown codes, fill to full
		send(REQ_POP, 8'd0);
		send(REQ_REMOVE, 8'd5);
		send(REQ_SELECT, 8'd0);
		send(REQ_MEMBER, 8'd255);
		send(REQ_SETWR, 8'd255, MODE_YOUNG, 16'd1, 16'hFFFF);
		send(REQ_SETWR, 8'd0, MODE_YOUNG, 16'd1, 16'd0);
		send(3'd6, 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF);
		send(3'd7, 8'd0);
		send(REQ_APPEND, 8'd255);
		send(REQ_APPEND, 8'd0);
		send(REQ_APPEND, 8'd7);
		send(REQ_SELECT, 8'd0, MODE_YOUNG);
		send(REQ_SELECT, 8'd0, MODE_OLD);
		send(REQ_SELECT, 8'd0, MODE_THRESH, 16'hFFFF);
		send(REQ_SELECT, 8'd0, MODE_THRESH, 16'd1);
		send(REQ_SELECT, 8'd0, 2'd3);
		send(REQ_MEMBER, 8'd7);
		send(REQ_REMOVE, 8'd0);
		send(REQ_REMOVE, 8'd99);
		drain();
		for (int i = 0; i < 256; i++) send(REQ_APPEND, i[7:0]);
		send(REQ_APPEND, 8'd1);
		send(REQ_SELECT, 8'd0, MODE_OLD);
		send(REQ_REMOVE, 8'd255);
		drain();
		while (model_len > 0 && model_len > 4) begin
			send(REQ_POP, 8'd0);
			model_len = model_len;
		end
		drain();
		// random part: mostly short lists, remove/test indexes drawn from a small pool
		for (int n = 0; n < 1400; n++) begin
			if (n > 1250) calm = 1'b1;
			if (n == 700) drain();
			mix = $urandom_range(0, 99);
			k = (mix < 80) ? $urandom_range(0, 15) : $urandom_range(0, 255);
			if (mix < 22) r = REQ_APPEND;
			else if (mix < 32) r = REQ_POP;
			else if (mix < 44) r = REQ_REMOVE;
			else if (mix < 54) r = REQ_MEMBER;
			else if (mix < 74) r = REQ_SELECT;
			else if (mix < 97) r = REQ_SETWR;
			else r = 3'($urandom_range(6, 7));
			send(r, k[7:0], 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
		end
		drain();
		repeat (300) @(posedge clk);
		$display("covered %0d results: empty, full, remove, select modes, set wear, odd codes",
			result_total);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
